@@ hdl/ddb_pkg.sv @@
package ddb_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;
	// day number of year 16383, december 31st, still fits
	localparam int DAYN_W  = 23;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [DAYN_W-1:0]  dayn_t;

	// per-stage load enables of the day number pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} ddb_adv_t;

	// floor(x / 100) for x below 2**15 as (x * DIV100_MUL) >> DIV100_SHIFT
	localparam logic [14:0] DIV100_MUL   = 15'd20972;
	localparam int          DIV100_SHIFT = 21;
	localparam logic [14:0] CENT_BIAS    = 15'd99;
	localparam logic [14:0] CENTURY      = 15'd100;
	localparam logic [22:0] YEAR_DAYS    = 23'd365;

	// days before the first of the month in a common year
	function automatic logic [8:0] days_before_month(input month_t m);
		logic [8:0] r;
		case (m)
			4'd0, 4'd1:         r = 9'd0;
			4'd2:               r = 9'd31;
			4'd3:               r = 9'd59;
			4'd4:               r = 9'd90;
			4'd5:               r = 9'd120;
			4'd6:               r = 9'd151;
			4'd7:               r = 9'd181;
			4'd8:               r = 9'd212;
			4'd9:               r = 9'd243;
			4'd10:              r = 9'd273;
			4'd11:              r = 9'd304;
			4'd12:              r = 9'd334;
			4'd13, 4'd14, 4'd15: r = 9'd365;
			default:            r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/ddb_dates_if.sv @@
interface ddb_dates_if;
	import ddb_pkg::*;

	logic   valid;
	logic   ready;
	year_t  first_year;
	month_t first_month;
	day_t   first_day;
	year_t  second_year;
	month_t second_month;
	day_t   second_day;

	modport source (
		output valid, first_year, first_month, first_day,
		output second_year, second_month, second_day,
		input  ready
	);

	modport sink (
		input  valid, first_year, first_month, first_day,
		input  second_year, second_month, second_day,
		output ready
	);

endinterface

@@ hdl/ddb_count_if.sv @@
interface ddb_count_if;
	import ddb_pkg::*;

	logic   valid;
	logic   ready;
	count_t day_count;

	modport source (
		output valid, day_count,
		input  ready
	);

	modport sink (
		input  valid, day_count,
		output ready
	);

endinterface

@@ hdl/ddb_day_num.sv @@
module ddb_day_num (
	input  logic              clk,
	input  ddb_pkg::ddb_adv_t adv,
	input  ddb_pkg::year_t    year,
	input  ddb_pkg::month_t   month,
	input  ddb_pkg::day_t     day,
	output ddb_pkg::dayn_t    day_num
);
	import ddb_pkg::*;

	// stage 1: reciprocal product for the century count
	logic [14:0] y_bias;
	logic [29:0] prod_full;

	year_t       year_s1;
	month_t      month_s1;
	day_t        day_s1;
	logic [28:0] prod_s1;

	always_comb begin
		y_bias    = 15'(year) + CENT_BIAS;
		prod_full = 30'(y_bias) * 30'(DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			prod_s1  <= prod_full[28:0];
		end
	end

	// stage 2: leap rule, leap count, whole years and month offset
	logic [7:0]  cent;
	logic [14:0] cent_x100;
	logic        cent_year;
	logic        leap;
	logic [14:0] quad_sum;
	logic [8:0]  qcent_sum;
	logic [12:0] leaps;
	logic [22:0] y365;
	logic [8:0]  mdays;

	dayn_t       y365_s2;
	logic [12:0] leaps_s2;
	logic [8:0]  mdays_s2;

	always_comb begin
		// ceil(year / 100)
		cent      = prod_s1[28:DIV100_SHIFT];
		cent_x100 = 15'(cent) * CENTURY;
		cent_year = (cent_x100 == 15'(year_s1));
		leap      = cent_year ? (cent[1:0] == 2'b00) : (year_s1[1:0] == 2'b00);
		quad_sum  = 15'(year_s1) + 15'd3;
		qcent_sum = 9'(cent) + 9'd3;
		leaps     = quad_sum[14:2] - 13'(cent) + 13'(qcent_sum[8:2]);
		y365      = 23'(year_s1) * YEAR_DAYS;
		mdays     = days_before_month(month_s1)
			+ 9'(leap && (month_s1 > 4'd2)) + 9'(day_s1);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			y365_s2  <= y365;
			leaps_s2 <= leaps;
			mdays_s2 <= mdays;
		end
	end

	// stage 3: final sum
	dayn_t num_s3;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			num_s3 <= y365_s2 + 23'(leaps_s2) + 23'(mdays_s2);
		end
	end

	assign day_num = num_s3;

endmodule

@@ hdl/ddb_abs_diff.sv @@
module ddb_abs_diff (
	input  logic           clk,
	input  logic           en,
	input  ddb_pkg::dayn_t num_a,
	input  ddb_pkg::dayn_t num_b,
	output ddb_pkg::count_t count
);
	import ddb_pkg::*;

	dayn_t  diff;
	dayn_t  incl;
	count_t count_s4;

	always_comb begin
		diff = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);
		incl = diff + 23'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s4 <= incl[COUNT_W-1:0];
		end
	end

	assign count = count_s4;

endmodule

@@ hdl/days_between_dates_unit.sv @@
// inclusive day count between two gregorian dates: each request carries two
// dates (year, month, day) and yields one result, |n1 - n2| + 1, where n is the
// closed-form day number (whole years with 4/100/400 leap rule, months before,
// plus day). either date may come first; fields are not range checked and any
// bit pattern gives the plain arithmetic result in 22 bits. the unit takes one
// request per clock while results are taken, and returns each result through
// the four register stages (reciprocal multiply, leap and year terms, day
// number sum, absolute difference). each stage holds its request only while
// the stage after it is full and stalled, so bubbles are squeezed out and a
// waiting result stops new requests only once all four stages are full.
module days_between_dates_unit (
	input  logic        clk,
	input  logic        arst_n,
	ddb_dates_if.sink   dates,
	ddb_count_if.source result
);
	import ddb_pkg::*;

	// valid bits that travel with each request
	logic v_s1, v_s2, v_s3, v_s4;

	// a stage loads when it is empty or its content moves on
	logic     en4;
	ddb_adv_t adv;

	assign en4    = !v_s4 || result.ready;
	assign adv.s3 = !v_s3 || en4;
	assign adv.s2 = !v_s2 || adv.s3;
	assign adv.s1 = !v_s1 || adv.s2;

	assign dates.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= dates.valid;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv.s3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// two day number pipelines share the stage enables
	dayn_t num_first;
	dayn_t num_second;

	ddb_day_num u_first (
		.clk     (clk),
		.adv     (adv),
		.year    (dates.first_year),
		.month   (dates.first_month),
		.day     (dates.first_day),
		.day_num (num_first)
	);

	ddb_day_num u_second (
		.clk     (clk),
		.adv     (adv),
		.year    (dates.second_year),
		.month   (dates.second_month),
		.day     (dates.second_day),
		.day_num (num_second)
	);

	// absolute difference plus one, held in the output register
	ddb_abs_diff u_diff (
		.clk   (clk),
		.en    (en4),
		.num_a (num_first),
		.num_b (num_second),
		.count (result.day_count)
	);

	assign result.valid = v_s4;

`ifndef SYNTHESIS
	// an accepted request always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.ready |=> v_s1)
		else $error("accepted request lost at stage 1");

	// a stalled result stays put
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !result.ready |=> v_s4)
		else $error("stalled result dropped");

	// stage 3 content moves into the output register when it frees up
	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 |=> v_s4)
		else $error("request lost between stage 3 and output");

	// a free output register never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready || !v_s4 |-> dates.ready)
		else $error("input stalled with free output");
`endif

endmodule

@@ verif/tb_days_between_dates_unit.sv @@
module tb_days_between_dates_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ddb_pkg::*;

	// one calendar date as it travels in a request
	typedef struct packed {
		year_t  year;
		month_t month;
		day_t   day;
	} date_t;

	// one row of the directed table: the two dates, and the count typed in
	// by hand where it is obvious (known_count set), else left to prediction
	typedef struct packed {
		date_t  first;
		date_t  second;
		logic   known_count;
		count_t count;
	} date_case_t;

	localparam int N_DIRECTED  = 21;
	localparam int N_RANDOM    = 1700;
	localparam int DRAIN_TICKS = 12;

	logic clk;
	logic arst_n;

	ddb_dates_if dates_bus ();
	ddb_count_if count_bus ();

	days_between_dates_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.dates  (dates_bus.sink),
		.result (count_bus.source)
	);

	// counts still owed by the unit, oldest first
	count_t expected_counts [$];
	int     error_count = 0;

	// hand-typed count that travels with the request on the bus
	logic   pinned_valid;
	count_t pinned_count;

	// sender burst bookkeeping
	int burst_left = 0;

	// years around leap rule corners and field limits
	int unsigned landmark_years [14] = '{0, 1, 3, 4, 99, 100, 400, 1600, 1700,
		1900, 2000, 2100, 9996, 9999};

	// directed table: extremes, order swap, leap corners, then the odd fields
	date_case_t directed_cases [N_DIRECTED] = '{
		// equal dates at both ends of the range
		'{'{14'd0, 4'd1, 5'd1}, '{14'd0, 4'd1, 5'd1}, 1'b1, 22'd1},
		'{'{14'd9999, 4'd12, 5'd31}, '{14'd9999, 4'd12, 5'd31}, 1'b1, 22'd1},
		// widest legal span, both orders
		'{'{14'd0, 4'd1, 5'd1}, '{14'd9999, 4'd12, 5'd31}, 1'b1, 22'd3652425},
		'{'{14'd9999, 4'd12, 5'd31}, '{14'd0, 4'd1, 5'd1}, 1'b1, 22'd3652425},
		// full leap and common years
		'{'{14'd2000, 4'd1, 5'd1}, '{14'd2000, 4'd12, 5'd31}, 1'b1, 22'd366},
		'{'{14'd1900, 4'd1, 5'd1}, '{14'd1900, 4'd12, 5'd31}, 1'b1, 22'd365},
		// across the end of february
		'{'{14'd2024, 4'd2, 5'd28}, '{14'd2024, 4'd3, 5'd1}, 1'b1, 22'd3},
		'{'{14'd2023, 4'd2, 5'd28}, '{14'd2023, 4'd3, 5'd1}, 1'b1, 22'd2},
		'{'{14'd1600, 4'd2, 5'd29}, '{14'd1600, 4'd3, 5'd1}, 1'b1, 22'd2},
		'{'{14'd2100, 4'd2, 5'd28}, '{14'd2100, 4'd3, 5'd1}, 1'b1, 22'd2},
		// across new year, year zero being leap
		'{'{14'd0, 4'd12, 5'd31}, '{14'd1, 4'd1, 5'd1}, 1'b1, 22'd2},
		'{'{14'd1999, 4'd12, 5'd31}, '{14'd2000, 4'd1, 5'd1}, 1'b1, 22'd2},
		// month zero and months past december
		'{'{14'd2020, 4'd0, 5'd5}, '{14'd2020, 4'd1, 5'd5}, 1'b0, 22'd0},
		'{'{14'd2020, 4'd13, 5'd1}, '{14'd2021, 4'd1, 5'd1}, 1'b0, 22'd0},
		'{'{14'd2019, 4'd15, 5'd31}, '{14'd2019, 4'd12, 5'd31}, 1'b0, 22'd0},
		// day zero and a day past the month end
		'{'{14'd2021, 4'd3, 5'd0}, '{14'd2021, 4'd2, 5'd28}, 1'b0, 22'd0},
		'{'{14'd2021, 4'd2, 5'd31}, '{14'd2021, 4'd3, 5'd3}, 1'b0, 22'd0},
		// years past 9999, and a count that no longer fits
		'{'{14'd10000, 4'd1, 5'd1}, '{14'd9999, 4'd12, 5'd31}, 1'b0, 22'd0},
		'{'{14'd16383, 4'd15, 5'd31}, '{14'd0, 4'd0, 5'd0}, 1'b0, 22'd0},
		'{'{14'd16383, 4'd15, 5'd31}, '{14'd16383, 4'd15, 5'd31}, 1'b1, 22'd1},
		// alternating bit patterns in every field
		'{'{14'd5461, 4'd10, 5'd21}, '{14'd10922, 4'd5, 5'd10}, 1'b0, 22'd0}
	};

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			2:             return is_leap(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// whole years since year 0, whole months before this one (at most twelve,
	// leap day included), then the day as it stands
	function automatic int unsigned day_number(date_t dt);
		int unsigned y;
		int unsigned n;
		y = dt.year;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int unsigned k = 1; k < dt.month && k <= 12; k++)
			n += month_length(y, k);
		return n + dt.day;
	endfunction

	function automatic count_t inclusive_days(date_t a, date_t b);
		int unsigned na;
		int unsigned nb;
		na = day_number(a);
		nb = day_number(b);
		return count_t'(((na > nb) ? na - nb : nb - na) + 1);
	endfunction

	function automatic date_t random_date(int unsigned lo, int unsigned hi);
		date_t dt;
		dt.year  = year_t'($urandom_range(hi, lo));
		dt.month = month_t'($urandom_range(12, 1));
		dt.day   = day_t'($urandom_range(month_length(dt.year, dt.month), 1));
		return dt;
	endfunction

	// date near a leap rule corner, months biased toward the year turn and
	// the end of february
	function automatic date_t landmark_date(int unsigned base);
		date_t       dt;
		int unsigned y;
		y = base + $urandom_range(1, 0);
		if (y > 9999)
			y = 9999;
		dt = random_date(y, y);
		if ($urandom_range(1, 0) == 0) begin
			case ($urandom_range(3, 0))
				0:       dt.month = 4'd1;
				1:       dt.month = 4'd2;
				2:       dt.month = 4'd3;
				default: dt.month = 4'd12;
			endcase
			dt.day = day_t'($urandom_range(month_length(y, dt.month), 1));
		end
		return dt;
	endfunction

	// raw bits, out-of-range fields included
	function automatic date_t noise_date();
		date_t dt;
		dt.year  = year_t'($urandom);
		dt.month = month_t'($urandom);
		dt.day   = day_t'($urandom);
		return dt;
	endfunction

	// one request: open a new burst after a random gap when the old one is
	// used up, then hold the request until the unit takes it
	task automatic send_dates(date_t a, date_t b, logic pin, count_t pin_value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(7, 1);
			if (gap != 0) begin
				dates_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(30, 1);
		end
		burst_left--;
		dates_bus.valid        <= 1'b1;
		dates_bus.first_year   <= a.year;
		dates_bus.first_month  <= a.month;
		dates_bus.first_day    <= a.day;
		dates_bus.second_year  <= b.year;
		dates_bus.second_month <= b.month;
		dates_bus.second_day   <= b.day;
		pinned_valid           <= pin;
		pinned_count           <= pin_value;
		do
			@(posedge clk);
		while (dates_bus.ready !== 1'b1);
	endtask

	// receiver: ready follows a 16-bit stall pattern, redrawn on each wrap;
	// some patterns are all ones, some are sparse, never all zeros
	initial begin : result_stalls
		logic [15:0] stall_bits;
		int          stall_phase;
		count_bus.ready = 1'b0;
		stall_bits      = 16'hFFFF;
		stall_phase     = 0;
		forever begin
			@(posedge clk);
			count_bus.ready <= stall_bits[stall_phase];
			stall_phase = (stall_phase + 1) % 16;
			if (stall_phase == 0) begin
				case ($urandom_range(3, 0))
					0:       stall_bits = 16'hFFFF;
					1:       stall_bits = 16'(($urandom & $urandom) | 32'h0001);
					default: stall_bits = 16'($urandom | 32'h0001);
				endcase
			end
		end
	end

	// scoreboard: results are checked before this edge's request is queued,
	// so ordering inside the time step does not matter
	always @(posedge clk) begin : count_check
		count_t want;
		if (count_bus.valid === 1'b1 && count_bus.ready === 1'b1) begin
			if (expected_counts.size() == 0) begin
				$error("day_count: unexpected result %0d", count_bus.day_count);
				error_count++;
			end else begin
				want = expected_counts.pop_front();
				if (count_bus.day_count !== want) begin
					$error("day_count mismatch: expected %0d, actual %0d",
						want, count_bus.day_count);
					error_count++;
				end
			end
		end
		if (dates_bus.valid === 1'b1 && dates_bus.ready === 1'b1) begin
			if (pinned_valid)
				expected_counts.push_back(pinned_count);
			else
				expected_counts.push_back(inclusive_days(
					'{dates_bus.first_year, dates_bus.first_month, dates_bus.first_day},
					'{dates_bus.second_year, dates_bus.second_month,
						dates_bus.second_day}));
		end
	end

	// main sequence: reset, directed table, random mix, drain
	initial begin : stimulus
		date_t a;
		date_t b;
		int    pick;
		arst_n                 = 1'b0;
		dates_bus.valid        = 1'b0;
		dates_bus.first_year   = '0;
		dates_bus.first_month  = '0;
		dates_bus.first_day    = '0;
		dates_bus.second_year  = '0;
		dates_bus.second_month = '0;
		dates_bus.second_day   = '0;
		pinned_valid           = 1'b0;
		pinned_count           = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_dates(directed_cases[i].first, directed_cases[i].second,
				directed_cases[i].known_count, directed_cases[i].count);

		// mostly legal dates anywhere, mixed with dates near leap corners and noise
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 60) begin
				a = random_date(0, 9999);
				b = ($urandom_range(3, 0) == 0) ? a : random_date(0, 9999);
				if ($urandom_range(3, 0) == 0)
					b = random_date(a.year, a.year);
			end else if (pick < 80) begin
				a = landmark_date(landmark_years[$urandom_range(13, 0)]);
				b = ($urandom_range(1, 0) == 0) ? landmark_date(a.year)
					: landmark_date(landmark_years[$urandom_range(13, 0)]);
			end else begin
				a = noise_date();
				b = ($urandom_range(1, 0) == 0) ? noise_date() : random_date(0, 9999);
			end
			send_dates(a, b, 1'b0, '0);
		end
		dates_bus.valid <= 1'b0;
		pinned_valid    <= 1'b0;

		// wait out the owed counts, then keep waiting for any stray result
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		if (error_count == 0)
			$display("** days_between_dates_unit: PASSED **");
		else
			$display("** days_between_dates_unit: FAILED **");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("** days_between_dates_unit: FAILED **");
		$finish;
	end

endmodule

@@ days_between_dates_unit.f @@
hdl/ddb_pkg.sv
hdl/ddb_dates_if.sv
hdl/ddb_count_if.sv
hdl/ddb_day_num.sv
hdl/ddb_abs_diff.sv
hdl/days_between_dates_unit.sv
verif/tb_days_between_dates_unit.sv
